>>> sv/assert_macros.svh
// Assertion macros used by the checker file of the overlay sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define EOTS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("overlay sequencer assertion failed");

// Concurrent assertion that is checked during reset as well.
`define EOTS_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("overlay sequencer assertion failed");

`endif

>>> sv/eots_pkg.sv
// Shared constants, codes and types of the eased overlay transition sequencer.
`default_nettype none

package eots_pkg;

   // Fixed point format of progress and alpha: Q1.FRAC_BITS.
   localparam int FRAC_BITS = 16;
   localparam int PW        = FRAC_BITS + 1;
   // The shared unit must hold a 17 bit remainder as well as a Q1.FRAC_BITS operand.
   localparam int UW        = (PW > 17) ? PW : 17;
   localparam int CW        = $clog2(UW + 1);
   localparam int AW        = (PW > 17) ? PW : 17;

   localparam logic [PW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PW-1:0] HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};

   // Shared unit operations.
   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;

   // Actions.
   localparam logic [2:0] ACT_TICK     = 3'd0;
   localparam logic [2:0] ACT_CLOSE    = 3'd1;
   localparam logic [2:0] ACT_OPEN     = 3'd2;
   localparam logic [2:0] ACT_COMPLETE = 3'd3;
   localparam logic [2:0] ACT_CANCEL   = 3'd4;

   // Phases.
   localparam logic [1:0] PH_IDLE      = 2'd0;
   localparam logic [1:0] PH_OPENING   = 2'd1;
   localparam logic [1:0] PH_CLOSING   = 2'd2;
   localparam logic [1:0] PH_COMPLETED = 2'd3;

   // Transition kinds.
   localparam logic [3:0] KIND_FADE     = 4'd0;
   localparam logic [3:0] KIND_SLIDE_L  = 4'd1;
   localparam logic [3:0] KIND_SLIDE_R  = 4'd2;
   localparam logic [3:0] KIND_SLIDE_U  = 4'd3;
   localparam logic [3:0] KIND_SLIDE_D  = 4'd4;
   localparam logic [3:0] KIND_WIPE_L   = 4'd5;
   localparam logic [3:0] KIND_WIPE_R   = 4'd6;
   localparam logic [3:0] KIND_CIRCLE_A = 4'd7;
   localparam logic [3:0] KIND_CIRCLE_B = 4'd8;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SCREEN_W   = 2'd0;
   localparam logic [1:0] CSR_SCREEN_H   = 2'd1;
   localparam logic [1:0] CSR_BASE_ALPHA = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [11:0] SCREEN_W_RST   = 12'd1280;
   localparam logic [11:0] SCREEN_H_RST   = 12'd720;
   localparam logic [16:0] BASE_ALPHA_RST = 17'(ONE);

   // Response transaction layout.
   localparam int RSP_W       = 88;
   localparam int RSP_VIS_BIT = 86;
   localparam int RSP_DONE_BIT = 87;

   typedef struct packed {
      logic          start;
      logic          op;
      logic [UW-1:0] a;
      logic [UW-1:0] b;
   } unit_req_type;

   typedef struct packed {
      logic            done;
      logic [2*UW-1:0] product;
   } unit_rsp_type;

endpackage

`default_nettype wire

>>> sv/eots_unit.sv
// Shared iterative unit: shift-add multiplier and restoring divider on one adder.
`default_nettype none

module eots_unit (
   input  wire                    clock,
   input  wire                    reset,
   input  wire eots_pkg::unit_req_type req,
   output eots_pkg::unit_rsp_type rsp
);

   localparam int UW = eots_pkg::UW;
   localparam int CW = eots_pkg::CW;

   logic [2*UW-1:0] p_ff, p_in;
   logic [UW-1:0]   a_ff, a_in;
   logic            op_ff, op_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;

   logic [UW-1:0]   hi, lo, r2, base, addend, rem_next;
   logic [UW:0]     sum;
   logic [2*UW-1:0] step_p;

   always_comb begin
      hi     = p_ff[2*UW-1:UW];
      lo     = p_ff[UW-1:0];
      r2     = {hi[UW-2:0], 1'b0};
      base   = (op_ff == eots_pkg::OP_MUL) ? hi : r2;
      addend = (op_ff == eots_pkg::OP_MUL) ? (lo[0] ? a_ff : {UW{1'b0}}) : ~a_ff;
      // For division the carry out of r2 + ~a + 1 tells r2 >= a.
      sum    = {1'b0, base} + {1'b0, addend} + {{UW{1'b0}}, (op_ff == eots_pkg::OP_DIV)};
      rem_next = sum[UW] ? sum[UW-1:0] : r2;
      if (op_ff == eots_pkg::OP_MUL) begin
         step_p = {sum, lo[UW-1:1]};
      end else begin
         step_p = {rem_next, lo[UW-2:0], sum[UW]};
      end
   end

   always_comb begin
      p_in    = p_ff;
      a_in    = a_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         a_in    = req.a;
         op_in   = req.op;
         busy_in = 1'b1;
         if (req.op == eots_pkg::OP_MUL) begin
            p_in   = {{UW{1'b0}}, req.b};
            cnt_in = CW'(UW);
         end else begin
            p_in   = {req.b, {UW{1'b0}}};
            cnt_in = CW'(eots_pkg::FRAC_BITS);
         end
      end else if (busy_ff) begin
         p_in   = step_p;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff  <= p_in;
      a_ff  <= a_in;
      op_ff <= op_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.product = p_ff;

endmodule

`default_nettype wire

>>> sv/eased_overlay_transition_sequencer_core.sv
// Top level of the eased overlay transition sequencer: state, sequencer and ports.
`default_nettype none

// The block steps one full-screen overlay through an eased transition. Each request
// transaction carries a tick or a command (start closing, start opening, complete
// now, cancel) and produces exactly one response transaction with the phase, the
// eased progress, the overlay alpha and the overlay rectangle. Commands and ticks
// outside an active phase finish in the cycle of acceptance. A tick in an active
// phase runs through one shared iterative unit: a restoring divide for the raw
// progress (skipped when the length is zero or the end is reached), then three
// shift-add multiplies (ease square, width scale, height scale). The request side
// is ready only while the sequencer is idle and the response register is empty or
// being emptied. Configuration writes go in at any time but are meant for idle
// periods.
module eased_overlay_transition_sequencer_core (
   input  wire                       clock,
   input  wire                       reset,
   // Request channel.
   input  wire                       req_tvalid,
   output logic                      req_tready,
   input  wire  [15:0]               req_tdata,   // [15:0] duration_ticks
   input  wire  [6:0]                req_tuser,   // [2:0] action, [6:3] kind
   // Response channel.
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   // [1:0] phase, [18:2] progress, [35:19] overlay_alpha, [48:36] pos_x,
   // [61:49] pos_y, [73:62] width_px, [85:74] height_px, [86] visible, [87] done_res
   output logic [eots_pkg::RSP_W-1:0] rsp_tdata,
   // Configuration write port.
   input  wire                       csr_write_enable,
   input  wire  [1:0]                csr_index,
   input  wire  [16:0]               csr_wdata
);

   localparam int PW = eots_pkg::PW;
   localparam int UW = eots_pkg::UW;
   localparam int AW = eots_pkg::AW;
   localparam int FB = eots_pkg::FRAC_BITS;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_DIV_GO    = 4'd1;
   localparam logic [3:0] ST_DIV_WAIT  = 4'd2;
   localparam logic [3:0] ST_EASE_GO   = 4'd3;
   localparam logic [3:0] ST_EASE_WAIT = 4'd4;
   localparam logic [3:0] ST_SW_GO     = 4'd5;
   localparam logic [3:0] ST_SW_WAIT   = 4'd6;
   localparam logic [3:0] ST_SH_GO     = 4'd7;
   localparam logic [3:0] ST_SH_WAIT   = 4'd8;
   localparam logic [3:0] ST_FINISH    = 4'd9;

   // Configuration registers.
   logic [11:0] scr_w_ff, scr_h_ff;
   logic [16:0] base_alpha_ff;

   // Transition state.
   logic [1:0]    phase_ff, phase_in;
   logic [15:0]   elapsed_ff, elapsed_in;
   logic [15:0]   length_ff, length_in;
   logic [3:0]    kind_ff, kind_in;
   logic [PW-1:0] prog_ff, prog_in;
   logic [12:0]   rect_x_ff, rect_x_in;
   logic [12:0]   rect_y_ff, rect_y_in;
   logic [11:0]   rect_w_ff, rect_w_in;
   logic [11:0]   rect_h_ff, rect_h_in;
   logic [PW-1:0] alpha_ff, alpha_in;

   // Working registers of an active tick.
   logic [3:0]    seq_ff, seq_in;
   logic [PW-1:0] raw_ff, raw_in;
   logic [PW-1:0] eff_ff, eff_in;
   logic [11:0]   sw_ff, sw_in;
   logic [11:0]   sh_ff, sh_in;

   // Response register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [eots_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   eots_pkg::unit_req_type unit_req;
   eots_pkg::unit_rsp_type unit_rsp;

   logic [2:0]    req_action;
   logic [3:0]    req_kind;
   logic          req_fire;
   logic          rsp_free;
   logic          phase_active;
   logic [15:0]   elapsed_inc;
   logic [PW:0]   u_wide;
   logic [PW-1:0] ease_u;
   logic          ease_low;
   logic [PW-1:0] p_low, p_high, p_new;
   logic [PW-1:0] base_sat;
   logic          load_rsp;
   logic          done_flag;

   eots_unit u_unit (
      .clock (clock),
      .reset (reset),
      .req   (unit_req),
      .rsp   (unit_rsp)
   );

   function automatic logic [eots_pkg::RSP_W-1:0] pack_rsp(
      input logic [1:0]    phase,
      input logic [PW-1:0] prog,
      input logic [PW-1:0] alpha,
      input logic [12:0]   x,
      input logic [12:0]   y,
      input logic [11:0]   w,
      input logic [11:0]   h,
      input logic          done
   );
      logic vis;
      vis = (phase != eots_pkg::PH_IDLE);
      return {done, vis, h, w, y, x, 17'(alpha), 17'(prog), phase};
   endfunction

   assign req_action   = req_tuser[2:0];
   assign req_kind     = req_tuser[6:3];
   assign rsp_free     = !rsp_valid_ff || rsp_tready;
   assign req_tready   = (seq_ff == ST_IDLE) && rsp_free;
   assign req_fire     = req_tvalid && req_tready;
   assign phase_active = (phase_ff == eots_pkg::PH_OPENING) ||
                         (phase_ff == eots_pkg::PH_CLOSING);
   assign elapsed_inc  = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;

   // Ease-in-out terms: the lower half squares t, the upper half squares 2 - 2t.
   assign u_wide   = ((PW+1)'(eots_pkg::ONE) << 1) - ((PW+1)'(raw_ff) << 1);
   assign ease_u   = u_wide[PW-1:0];
   assign ease_low = (raw_ff < eots_pkg::HALF);
   assign p_low    = PW'(unit_rsp.product >> (FB - 1));
   assign p_high   = eots_pkg::ONE - PW'(unit_rsp.product >> (FB + 1));
   assign p_new    = ease_low ? p_low : p_high;

   // Base alpha values above one are used as one.
   assign base_sat = (AW'(base_alpha_ff) > AW'(eots_pkg::ONE)) ? eots_pkg::ONE
                                                               : PW'(base_alpha_ff);

   always_comb begin
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      length_in    = length_ff;
      kind_in      = kind_ff;
      prog_in      = prog_ff;
      rect_x_in    = rect_x_ff;
      rect_y_in    = rect_y_ff;
      rect_w_in    = rect_w_ff;
      rect_h_in    = rect_h_ff;
      alpha_in     = alpha_ff;
      seq_in       = seq_ff;
      raw_in       = raw_ff;
      eff_in       = eff_ff;
      sw_in        = sw_ff;
      sh_in        = sh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      load_rsp     = 1'b0;
      done_flag    = 1'b0;
      unit_req.start = 1'b0;
      unit_req.op    = eots_pkg::OP_MUL;
      unit_req.a     = UW'(eff_ff);
      unit_req.b     = UW'(scr_w_ff);

      unique case (seq_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_action) inside
                  eots_pkg::ACT_TICK: begin
                     if (phase_active) begin
                        elapsed_in = elapsed_inc;
                        // Once elapsed reaches the length the quotient is at least one.
                        if (length_ff == 16'd0 || elapsed_inc >= length_ff) begin
                           raw_in = eots_pkg::ONE;
                           seq_in = ST_EASE_GO;
                        end else begin
                           seq_in = ST_DIV_GO;
                        end
                     end else begin
                        load_rsp = 1'b1;
                     end
                  end
                  eots_pkg::ACT_CLOSE, eots_pkg::ACT_OPEN: begin
                     kind_in    = req_kind;
                     length_in  = req_tdata;
                     elapsed_in = 16'd0;
                     prog_in    = '0;
                     phase_in   = (req_action == eots_pkg::ACT_CLOSE) ? eots_pkg::PH_CLOSING
                                                                      : eots_pkg::PH_OPENING;
                     load_rsp   = 1'b1;
                  end
                  eots_pkg::ACT_COMPLETE: begin
                     phase_in  = eots_pkg::PH_COMPLETED;
                     prog_in   = eots_pkg::ONE;
                     done_flag = 1'b1;
                     load_rsp  = 1'b1;
                  end
                  eots_pkg::ACT_CANCEL: begin
                     phase_in   = eots_pkg::PH_IDLE;
                     prog_in    = '0;
                     elapsed_in = 16'd0;
                     load_rsp   = 1'b1;
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         ST_DIV_GO: begin
            unit_req.start = 1'b1;
            unit_req.op    = eots_pkg::OP_DIV;
            unit_req.a     = UW'(length_ff);
            unit_req.b     = UW'(elapsed_ff);
            seq_in         = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (unit_rsp.done) begin
               raw_in = PW'(unit_rsp.product[FB-1:0]);
               seq_in = ST_EASE_GO;
            end
         end
         ST_EASE_GO: begin
            unit_req.start = 1'b1;
            unit_req.op    = eots_pkg::OP_MUL;
            unit_req.a     = ease_low ? UW'(raw_ff) : UW'(ease_u);
            unit_req.b     = ease_low ? UW'(raw_ff) : UW'(ease_u);
            seq_in         = ST_EASE_WAIT;
         end
         ST_EASE_WAIT: begin
            if (unit_rsp.done) begin
               prog_in = p_new;
               eff_in  = (phase_ff == eots_pkg::PH_OPENING) ? eots_pkg::ONE - p_new : p_new;
               seq_in  = ST_SW_GO;
            end
         end
         ST_SW_GO: begin
            unit_req.start = 1'b1;
            unit_req.a     = UW'(eff_ff);
            unit_req.b     = UW'(scr_w_ff);
            seq_in         = ST_SW_WAIT;
         end
         ST_SW_WAIT: begin
            if (unit_rsp.done) begin
               sw_in  = 12'(unit_rsp.product >> FB);
               seq_in = ST_SH_GO;
            end
         end
         ST_SH_GO: begin
            unit_req.start = 1'b1;
            unit_req.a     = UW'(eff_ff);
            unit_req.b     = UW'(scr_h_ff);
            seq_in         = ST_SH_WAIT;
         end
         ST_SH_WAIT: begin
            if (unit_rsp.done) begin
               sh_in  = 12'(unit_rsp.product >> FB);
               seq_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               case (kind_ff) inside
                  eots_pkg::KIND_FADE, eots_pkg::KIND_CIRCLE_A, eots_pkg::KIND_CIRCLE_B: begin
                     alpha_in = eff_ff;
                  end
                  eots_pkg::KIND_SLIDE_L: begin
                     rect_x_in = 13'(sw_ff) - 13'(scr_w_ff);
                     rect_y_in = 13'd0;
                     alpha_in  = base_sat;
                  end
                  eots_pkg::KIND_SLIDE_R: begin
                     rect_x_in = 13'(scr_w_ff) - 13'(sw_ff);
                     rect_y_in = 13'd0;
                     alpha_in  = base_sat;
                  end
                  eots_pkg::KIND_SLIDE_U: begin
                     rect_x_in = 13'd0;
                     rect_y_in = 13'(sh_ff) - 13'(scr_h_ff);
                     alpha_in  = base_sat;
                  end
                  eots_pkg::KIND_SLIDE_D: begin
                     rect_x_in = 13'd0;
                     rect_y_in = 13'(scr_h_ff) - 13'(sh_ff);
                     alpha_in  = base_sat;
                  end
                  eots_pkg::KIND_WIPE_L, eots_pkg::KIND_WIPE_R: begin
                     rect_w_in = sw_ff;
                     rect_h_in = scr_h_ff;
                     rect_x_in = (kind_ff == eots_pkg::KIND_WIPE_R)
                                 ? 13'(scr_w_ff) - 13'(sw_ff) : 13'd0;
                     rect_y_in = 13'd0;
                     alpha_in  = base_sat;
                  end
                  default: begin
                     // Unassigned kinds only advance progress and phase.
                  end
               endcase
               if (raw_ff == eots_pkg::ONE) begin
                  phase_in  = eots_pkg::PH_COMPLETED;
                  done_flag = 1'b1;
               end
               load_rsp = 1'b1;
               seq_in   = ST_IDLE;
            end
         end
         default: begin
            seq_in = ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pack_rsp(phase_in, prog_in, alpha_in, rect_x_in, rect_y_in,
                                 rect_w_in, rect_h_in, done_flag);
      end
   end

   // Configuration writes; indexes beyond the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff      <= eots_pkg::SCREEN_W_RST;
         scr_h_ff      <= eots_pkg::SCREEN_H_RST;
         base_alpha_ff <= eots_pkg::BASE_ALPHA_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            eots_pkg::CSR_SCREEN_W:   scr_w_ff      <= csr_wdata[11:0];
            eots_pkg::CSR_SCREEN_H:   scr_h_ff      <= csr_wdata[11:0];
            eots_pkg::CSR_BASE_ALPHA: base_alpha_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      raw_ff      <= raw_in;
      eff_ff      <= eff_in;
      sw_ff       <= sw_in;
      sh_ff       <= sh_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         phase_ff     <= eots_pkg::PH_IDLE;
         elapsed_ff   <= 16'd0;
         length_ff    <= 16'd0;
         kind_ff      <= eots_pkg::KIND_FADE;
         prog_ff      <= '0;
         rect_x_ff    <= 13'd0;
         rect_y_ff    <= 13'd0;
         rect_w_ff    <= eots_pkg::SCREEN_W_RST;
         rect_h_ff    <= eots_pkg::SCREEN_H_RST;
         alpha_ff     <= eots_pkg::ONE;
         seq_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         length_ff    <= length_in;
         kind_ff      <= kind_in;
         prog_ff      <= prog_in;
         rect_x_ff    <= rect_x_in;
         rect_y_ff    <= rect_y_in;
         rect_w_ff    <= rect_w_in;
         rect_h_ff    <= rect_h_in;
         alpha_ff     <= alpha_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> sv/eots_checker.sv
// Port-level assertions of the overlay sequencer and the bind that attaches them.
`default_nettype none

`include "assert_macros.svh"

module eots_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_tready,
   input wire                       rsp_tvalid,
   input wire                       rsp_tready,
   input wire [eots_pkg::RSP_W-1:0] rsp_tdata
);

   logic [1:0] rsp_phase;
   logic       rsp_visible;
   logic       rsp_done;
   logic       rsp_stall;
   logic       rsp_completed;
   logic       rsp_idle;

   assign rsp_phase     = rsp_tdata[1:0];
   assign rsp_visible   = rsp_tdata[eots_pkg::RSP_VIS_BIT];
   assign rsp_done      = rsp_tdata[eots_pkg::RSP_DONE_BIT];
   assign rsp_stall     = rsp_tvalid && !rsp_tready;
   assign rsp_completed = (rsp_phase == eots_pkg::PH_COMPLETED);
   assign rsp_idle      = (rsp_phase == eots_pkg::PH_IDLE);

   // A stalled response transaction stays put.
   `EOTS_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata))

   // No request is taken while the response register is full and stalled.
   `EOTS_ASSERT(a_no_accept_on_stall, clock, reset, rsp_stall |-> !req_tready)

   // A completion pulse always reports the completed phase.
   `EOTS_ASSERT(a_done_completed, clock, reset, rsp_tvalid && rsp_done |-> rsp_completed)

   // Visible follows the reported phase.
   `EOTS_ASSERT(a_visible_phase, clock, reset, rsp_tvalid |-> rsp_visible == !rsp_idle)

   // Reset empties the response register.
   `EOTS_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_tvalid)

endmodule

bind eased_overlay_transition_sequencer_core eots_checker u_eots_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> verif/tb_eased_overlay_transition_sequencer_core.sv
// Self-checking testbench of the eased overlay transition sequencer core.
`timescale 1ns / 100ps

// The testbench drives request transactions (ticks and commands) into the sequencer and
// checks every response transaction, field by field, against an expected view of the
// overlay. A short directed table comes first. Its simple rows (reset state, fixed-point
// extremes, complete and cancel) carry hand-written views. All other rows, and the
// random transitions that follow, are checked against a predictor that keeps its own
// copy of the sequencer state and of the screen setup. The screen setup is rewritten
// between phases of the run, and only while the block is idle.
module tb_eased_overlay_transition_sequencer_core;
   import eots_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 5;
   localparam int RANDOM_ITEMS   = 1650;
   // Sequences between two rewrites of the screen setup.
   localparam int SETUP_EVERY    = 12;
   // The pause outlasts the busy time of an active tick.
   localparam int SETTLE_CYCLES  = 90;
   // Long receiver hold-off that backs the block up into its request side.
   localparam int HOLD_CYCLES    = 600;
   localparam int HOLD_AT_RSP    = 250;
   // The slowest gap between two transactions, the receiver hold-off and a setup pause
   // all stay well below this limit, so the watchdog has plenty of margin.
   localparam int WATCHDOG_LIMIT = 5000;

   // Action codes the block ignores, kinds outside the named set, and the unused
   // register index.
   localparam logic [2:0] ACT_SPARE_A    = 3'd5;
   localparam logic [2:0] ACT_SPARE_B    = 3'd6;
   localparam logic [2:0] ACT_SPARE_C    = 3'd7;
   localparam logic [3:0] KIND_SPARE_MIN = 4'd9;
   localparam logic [3:0] KIND_SPARE_MAX = 4'd15;
   localparam logic [1:0] CSR_UNUSED     = 2'd3;

   localparam longint unsigned UNIT = 64'(ONE);

   // One response transaction, unpacked into its fields.
   typedef struct packed {
      logic [1:0]  phase;
      logic [16:0] progress;
      logic [16:0] alpha;
      logic [12:0] pos_x;
      logic [12:0] pos_y;
      logic [11:0] width;
      logic [11:0] height;
      logic        visible;
      logic        done;
   } overlay_view_t;

   typedef struct packed {
      logic [2:0]    action;
      logic [3:0]    kind;
      logic [15:0]   dur;
      logic          has_view;
      overlay_view_t view;
   } directed_row_t;

   // Views that can be written down by hand at the reset screen setup.
   localparam overlay_view_t VIEW_RESET = '{phase: PH_IDLE, progress: 17'd0, alpha: ONE,
      pos_x: 13'd0, pos_y: 13'd0, width: 12'd1280, height: 12'd720, visible: 1'b0,
      done: 1'b0};
   localparam overlay_view_t VIEW_DONE = '{phase: PH_COMPLETED, progress: ONE, alpha: ONE,
      pos_x: 13'd0, pos_y: 13'd0, width: 12'd1280, height: 12'd720, visible: 1'b1,
      done: 1'b1};
   localparam overlay_view_t VIEW_DONE_HELD = '{phase: PH_COMPLETED, progress: ONE,
      alpha: ONE, pos_x: 13'd0, pos_y: 13'd0, width: 12'd1280, height: 12'd720,
      visible: 1'b1, done: 1'b0};
   localparam overlay_view_t VIEW_ARMED_CLOSE = '{phase: PH_CLOSING, progress: 17'd0,
      alpha: ONE, pos_x: 13'd0, pos_y: 13'd0, width: 12'd1280, height: 12'd720,
      visible: 1'b1, done: 1'b0};
   localparam overlay_view_t VIEW_ARMED_OPEN = '{phase: PH_OPENING, progress: 17'd0,
      alpha: ONE, pos_x: 13'd0, pos_y: 13'd0, width: 12'd1280, height: 12'd720,
      visible: 1'b1, done: 1'b0};
   localparam overlay_view_t VIEW_FADED_OUT = '{phase: PH_COMPLETED, progress: ONE,
      alpha: 17'd0, pos_x: 13'd0, pos_y: 13'd0, width: 12'd1280, height: 12'd720,
      visible: 1'b1, done: 1'b1};

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_tvalid       = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata        = 16'd0;
   logic [6:0]  req_tuser        = 7'd0;
   logic        rsp_tvalid;
   logic        rsp_tready       = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index        = CSR_SCREEN_W;
   logic [16:0] csr_wdata        = 17'd0;

   // Predicted screen setup and sequencer state.
   logic [11:0] setup_width  = SCREEN_W_RST;
   logic [11:0] setup_height = SCREEN_H_RST;
   logic [16:0] setup_alpha  = BASE_ALPHA_RST;
   logic [1:0]  cur_phase    = PH_IDLE;
   logic [15:0] cur_elapsed  = 16'd0;
   logic [15:0] cur_length   = 16'd0;
   logic [3:0]  cur_kind     = KIND_FADE;
   logic [16:0] cur_progress = 17'd0;
   logic [16:0] cur_alpha    = BASE_ALPHA_RST;
   logic [12:0] cur_x        = 13'd0;
   logic [12:0] cur_y        = 13'd0;
   logic [11:0] cur_w        = SCREEN_W_RST;
   logic [11:0] cur_h        = SCREEN_H_RST;

   overlay_view_t pending_views[$];
   directed_row_t directed_plan[24];
   int mismatches   = 0;
   int quiet_cycles = 0;
   int counted_items;

   eased_overlay_transition_sequencer_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Steps the predicted sequencer by one request and returns the overlay it reports.
   // The elapsed count saturates at its maximum, but a transition completes as soon as
   // the count reaches the length, so the saturation itself never shows in a response.
   function automatic overlay_view_t predict_overlay(input logic [2:0] action,
                                                     input logic [3:0] kind,
                                                     input logic [15:0] dur);
      longint unsigned raw, eased, eff, u, w, h, sw, sh;
      logic [16:0] alpha_cap;
      logic done_now;
      overlay_view_t v;
      done_now  = 1'b0;
      alpha_cap = (setup_alpha > ONE) ? ONE : setup_alpha;
      case (action)
         ACT_TICK: begin
            if (cur_phase == PH_OPENING || cur_phase == PH_CLOSING) begin
               if (cur_elapsed != 16'hFFFF) cur_elapsed = cur_elapsed + 16'd1;
               if (cur_length == 16'd0) begin
                  raw = UNIT;
               end else begin
                  raw = (64'(cur_elapsed) << FRAC_BITS) / 64'(cur_length);
                  if (raw > UNIT) raw = UNIT;
               end
               // Quadratic ease-in-out: a parabola up to half way, its mirror after.
               if (raw < UNIT / 2) begin
                  eased = (2 * raw * raw) >> FRAC_BITS;
               end else begin
                  u     = 2 * UNIT - 2 * raw;
                  eased = UNIT - ((u * u) >> (FRAC_BITS + 1));
               end
               cur_progress = 17'(eased);
               // Opening runs the same curve backwards.
               eff = (cur_phase == PH_OPENING) ? UNIT - eased : eased;
               w   = 64'(setup_width);
               h   = 64'(setup_height);
               sw  = (w * eff) >> FRAC_BITS;
               sh  = (h * eff) >> FRAC_BITS;
               case (cur_kind)
                  KIND_FADE, KIND_CIRCLE_A, KIND_CIRCLE_B: begin
                     cur_alpha = 17'(eff);
                  end
                  KIND_SLIDE_L: begin
                     cur_x = 13'(sw - w);
                     cur_y = 13'd0;
                     cur_alpha = alpha_cap;
                  end
                  KIND_SLIDE_R: begin
                     cur_x = 13'(w - sw);
                     cur_y = 13'd0;
                     cur_alpha = alpha_cap;
                  end
                  KIND_SLIDE_U: begin
                     cur_x = 13'd0;
                     cur_y = 13'(sh - h);
                     cur_alpha = alpha_cap;
                  end
                  KIND_SLIDE_D: begin
                     cur_x = 13'd0;
                     cur_y = 13'(h - sh);
                     cur_alpha = alpha_cap;
                  end
                  KIND_WIPE_L, KIND_WIPE_R: begin
                     cur_w = 12'(sw);
                     cur_h = setup_height;
                     cur_x = (cur_kind == KIND_WIPE_R) ? 13'(w - sw) : 13'd0;
                     cur_y = 13'd0;
                     cur_alpha = alpha_cap;
                  end
                  default: begin
                     // Kinds past the named set only advance the progress.
                  end
               endcase
               if (raw >= UNIT) begin
                  cur_phase = PH_COMPLETED;
                  done_now  = 1'b1;
               end
            end
         end
         ACT_CLOSE, ACT_OPEN: begin
            // The rectangle and alpha stay as they are until the first tick.
            cur_kind     = kind;
            cur_length   = dur;
            cur_elapsed  = 16'd0;
            cur_progress = 17'd0;
            cur_phase    = (action == ACT_CLOSE) ? PH_CLOSING : PH_OPENING;
         end
         ACT_COMPLETE: begin
            cur_phase    = PH_COMPLETED;
            cur_progress = ONE;
            done_now     = 1'b1;
         end
         ACT_CANCEL: begin
            cur_phase    = PH_IDLE;
            cur_progress = 17'd0;
            cur_elapsed  = 16'd0;
         end
         default: begin
            // Spare action codes just report the current state.
         end
      endcase
      v.phase    = cur_phase;
      v.progress = cur_progress;
      v.alpha    = cur_alpha;
      v.pos_x    = cur_x;
      v.pos_y    = cur_y;
      v.width    = cur_w;
      v.height   = cur_h;
      v.visible  = (cur_phase != PH_IDLE);
      v.done     = done_now;
      return v;
   endfunction

   // Offers one request transaction after a random gap and waits for its acceptance.
   // The prediction is taken at the accepting edge; a hand-written view, when given,
   // replaces it as the expectation while the predictor still advances.
   task automatic send_request(input logic [2:0] action, input logic [3:0] kind,
                               input logic [15:0] dur, input logic has_view = 1'b0,
                               input overlay_view_t fixed_view = '0);
      int gap;
      overlay_view_t predicted;
      // Every 200 items there is a stretch of 40 sent back to back.
      gap = ((counted_items % 200) < 40) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= dur;
      req_tuser  <= {kind, action};
      do @(posedge clock); while (!req_tready);
      predicted = predict_overlay(action, kind, dur);
      pending_views.push_back(has_view ? fixed_view : predicted);
      if (action <= ACT_CANCEL) counted_items++;
   endtask

   // Rewrites the screen setup once the block has drained and settled.
   task automatic write_screen_setup(input logic [11:0] w, input logic [11:0] h,
                                     input logic [16:0] alpha);
      logic [16:0] junk;
      req_tvalid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      // Width and height carry random upper bits, which the block must drop.
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SCREEN_W;
      csr_wdata        <= {5'($urandom), w};
      setup_width       = w;
      @(posedge clock);
      csr_index        <= CSR_SCREEN_H;
      csr_wdata        <= {5'($urandom), h};
      setup_height      = h;
      @(posedge clock);
      csr_index        <= CSR_BASE_ALPHA;
      csr_wdata        <= alpha;
      setup_alpha       = alpha;
      @(posedge clock);
      // A write to the unused index must change nothing.
      junk              = 17'($urandom);
      csr_index        <= CSR_UNUSED;
      csr_wdata        <= junk;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One transition with random content: a start, a run of ticks with the odd
   // interruption, and sometimes a final cancel or complete command.
   task automatic run_random_transition();
      logic [2:0] start_act;
      logic [3:0] kind;
      logic [15:0] dur;
      int ticks, roll;
      start_act = ($urandom_range(0, 1) == 0) ? ACT_CLOSE : ACT_OPEN;
      kind = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8))
                                          : 4'($urandom_range(KIND_SPARE_MIN, KIND_SPARE_MAX));
      roll = $urandom_range(0, 99);
      if (roll < 70)      dur = 16'($urandom_range(0, 10));
      else if (roll < 90) dur = 16'($urandom_range(11, 40));
      else                dur = 16'($urandom);
      ticks = (dur <= 16'd40) ? int'(dur) + $urandom_range(0, 2) : $urandom_range(1, 6);
      send_request(start_act, kind, dur);
      repeat (ticks) begin
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            send_request(ACT_CANCEL, 4'($urandom), 16'($urandom));
         end else if (roll < 4) begin
            send_request(ACT_COMPLETE, 4'($urandom), 16'($urandom));
         end else if (roll < 6) begin
            send_request(3'($urandom_range(ACT_SPARE_A, ACT_SPARE_C)), 4'($urandom),
                         16'($urandom));
         end else if (roll < 8) begin
            // Restart in the middle of a transition.
            send_request(start_act, 4'($urandom_range(0, 8)), 16'($urandom_range(0, 12)));
         end else begin
            send_request(ACT_TICK, 4'($urandom), 16'($urandom));
         end
      end
      roll = $urandom_range(0, 99);
      if (roll < 30)      send_request(ACT_CANCEL, 4'($urandom), 16'($urandom));
      else if (roll < 45) send_request(ACT_COMPLETE, 4'($urandom), 16'($urandom));
   endtask

   // Stimulus: reset, the directed table, random transitions between setup rewrites,
   // then the drain and the verdict.
   initial begin : stimulus
      int seq_count;
      int setup_count;
      logic [11:0] w, h;
      logic [16:0] alpha;
      directed_plan = '{
         '{ACT_TICK,     KIND_FADE,      16'd0,     1'b1, VIEW_RESET},
         '{ACT_SPARE_A,  KIND_SPARE_MAX, 16'hFFFF,  1'b1, VIEW_RESET},
         '{ACT_SPARE_C,  KIND_FADE,      16'd0,     1'b1, VIEW_RESET},
         '{ACT_COMPLETE, KIND_FADE,      16'd0,     1'b1, VIEW_DONE},
         '{ACT_TICK,     KIND_FADE,      16'd0,     1'b1, VIEW_DONE_HELD},
         '{ACT_CANCEL,   KIND_FADE,      16'd0,     1'b1, VIEW_RESET},
         // Zero length completes on the first tick, at full or no alpha.
         '{ACT_CLOSE,    KIND_FADE,      16'd0,     1'b1, VIEW_ARMED_CLOSE},
         '{ACT_TICK,     KIND_FADE,      16'd0,     1'b1, VIEW_DONE},
         '{ACT_OPEN,     KIND_FADE,      16'd0,     1'b1, VIEW_ARMED_OPEN},
         '{ACT_TICK,     KIND_FADE,      16'd0,     1'b1, VIEW_FADED_OUT},
         '{ACT_CLOSE,    KIND_SLIDE_L,   16'd2,     1'b0, '0},
         '{ACT_TICK,     KIND_FADE,      16'd0,     1'b0, '0},
         '{ACT_TICK,     KIND_FADE,      16'd0,     1'b0, '0},
         '{ACT_OPEN,     KIND_WIPE_R,    16'd1,     1'b0, '0},
         '{ACT_TICK,     KIND_FADE,      16'd0,     1'b0, '0},
         // Longest length with a kind outside the named set.
         '{ACT_CLOSE,    KIND_SPARE_MAX, 16'hFFFF,  1'b0, '0},
         '{ACT_TICK,     KIND_SPARE_MAX, 16'hFFFF,  1'b0, '0},
         '{ACT_OPEN,     KIND_SLIDE_D,   16'd3,     1'b0, '0},
         '{ACT_TICK,     KIND_FADE,      16'd0,     1'b0, '0},
         '{ACT_COMPLETE, KIND_FADE,      16'd0,     1'b0, '0},
         '{ACT_CLOSE,    KIND_CIRCLE_B,  16'd2,     1'b0, '0},
         '{ACT_TICK,     KIND_FADE,      16'd0,     1'b0, '0},
         '{ACT_CANCEL,   KIND_FADE,      16'd0,     1'b0, '0},
         '{ACT_SPARE_B,  KIND_FADE,      16'd0,     1'b0, '0}
      };
      counted_items = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) begin
         send_request(directed_plan[i].action, directed_plan[i].kind, directed_plan[i].dur,
                      directed_plan[i].has_view, directed_plan[i].view);
      end

      counted_items = 0;
      seq_count     = 0;
      setup_count   = 0;
      while (counted_items < RANDOM_ITEMS) begin
         if (seq_count % SETUP_EVERY == 0) begin
            // The first settings sit at the extremes of every register, including a
            // base alpha above one, which the block clips.
            case (setup_count)
               0: begin w = 12'd1;    h = 12'd1;    alpha = 17'd0;      end
               1: begin w = 12'd4095; h = 12'd4095; alpha = ONE;        end
               2: begin w = 12'd4095; h = 12'd1;    alpha = 17'h1FFFF;  end
               3: begin w = 12'd1;    h = 12'd4095; alpha = ONE - 17'd1; end
               default: begin
                  w     = 12'($urandom_range(1, 4095));
                  h     = 12'($urandom_range(1, 4095));
                  alpha = 17'($urandom);
               end
            endcase
            write_screen_setup(w, h, alpha);
            setup_count++;
         end
         if ($urandom_range(0, 9) == 0) begin
            // Noise: a few items with every field random.
            repeat ($urandom_range(1, 4)) begin
               send_request(3'($urandom), 4'($urandom), 16'($urandom));
            end
         end else begin
            run_random_transition();
         end
         seq_count++;
      end

      req_tvalid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_views.size() == 0)
         $display("tb_eased_overlay_transition_sequencer_core passed");
      else
         $display("tb_eased_overlay_transition_sequencer_core failed");
      $finish;
   end

   // Response side: a random stall before each transaction, stretches without stalls,
   // and one long hold-off that fills the block while the sender keeps offering.
   initial begin : response_sink
      int gap;
      int taken;
      taken = 0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (taken == HOLD_AT_RSP) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = ((taken % 170) < 35) ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   task automatic check_field(input string name, input logic [16:0] want,
                              input logic [16:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Checks each accepted response against the oldest expectation and keeps the
   // watchdog on transactions of either channel.
   always @(posedge clock) begin
      overlay_view_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_views.size() == 0) begin
               $error("response transaction with no expectation waiting");
               mismatches++;
            end else begin
               want = pending_views.pop_front();
               check_field("phase",         17'(want.phase),    17'(rsp_tdata[1:0]));
               check_field("progress",      want.progress,      rsp_tdata[18:2]);
               check_field("overlay_alpha", want.alpha,         rsp_tdata[35:19]);
               check_field("pos_x",         17'(want.pos_x),    17'(rsp_tdata[48:36]));
               check_field("pos_y",         17'(want.pos_y),    17'(rsp_tdata[61:49]));
               check_field("width_px",      17'(want.width),    17'(rsp_tdata[73:62]));
               check_field("height_px",     17'(want.height),   17'(rsp_tdata[85:74]));
               check_field("visible",       17'(want.visible),  17'(rsp_tdata[RSP_VIS_BIT]));
               check_field("done_res",      17'(want.done),     17'(rsp_tdata[RSP_DONE_BIT]));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_eased_overlay_transition_sequencer_core failed");
            $finish;
         end
      end
   end

endmodule

>>> files.f
+incdir+sv
sv/eots_pkg.sv
sv/eots_unit.sv
sv/eased_overlay_transition_sequencer_core.sv
sv/eots_checker.sv
verif/tb_eased_overlay_transition_sequencer_core.sv
